[hdl/hdp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hex dump parser package
// Shared payload types, line phase encoding, character codes and the
// hex digit decoder used by the hex dump text parser.
// ---------------------------------------------------------------------------
package hdp_pkg;

    // Character codes recognized by the parser.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;

    // Counter width and byte limit reset value.
    localparam int unsigned CNT_W = 21;
    localparam logic [CNT_W-1:0] BYTE_LIMIT_RESET = 21'h100000;

    // Depth of the result queue; it must hold two results of one character.
    localparam int unsigned RESQ_DEPTH = 4;

    // Where the parser stands within the current line.
    typedef enum logic [1:0] {
        PH_OFFSET  = 2'd0,
        PH_PAIR    = 2'd1,
        PH_SECOND  = 2'd2,
        PH_DISCARD = 2'd3
    } t_phase;

    // One input transaction.
    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_in;

    // One result transaction.
    typedef struct packed {
        logic [7:0]       byte_value;
        logic             is_byte;
        logic             is_summary;
        logic [CNT_W-1:0] bytes_emitted;
        logic             nothing_parsed;
        logic             end_of_run;
    } t_out;

    // Results produced by one character, in delivery order.
    typedef struct packed {
        logic first_valid;
        t_out first;
        logic second_valid;
        t_out second;
    } t_push;

    // Returns {is_hex, nibble} for an ASCII code.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[hdl/hdp_parse.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hex dump parser line engine
// Holds the per-line state and the byte count, applies the character rule
// for one registered character per cycle when i_fire is high, and forms up to two results.
// ---------------------------------------------------------------------------
module hdp_parse #(
    parameter int unsigned PAIRS_PER_LINE  = 16,
    parameter int unsigned OFFSET_SKIP_MAX = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  hdp_pkg::t_in              i_item,
    input  logic [hdp_pkg::CNT_W-1:0] i_byte_limit,
    output hdp_pkg::t_push            o_push
);
    import hdp_pkg::*;

    localparam int unsigned PAIR_W = $clog2(PAIRS_PER_LINE + 1);
    localparam int unsigned OFF_W  = $clog2(OFFSET_SKIP_MAX + 1);

    t_phase            r_phase, n_phase;
    logic [OFF_W-1:0]  r_off,   n_off;
    logic [PAIR_W-1:0] r_pairs, n_pairs;
    logic [7:0]        r_first, n_first;
    logic [CNT_W-1:0]  r_total, n_total;

    logic       emit;
    logic [4:0] hi_dig;
    logic [4:0] lo_dig;
    t_out       byte_res;
    t_out       sum_res;

    assign hi_dig = hex_digit(r_first);
    assign lo_dig = hex_digit(i_item.text_char);

    // Character rule: next line state, byte count and byte emission.
    always_comb begin
        n_phase = r_phase;
        n_off   = r_off;
        n_pairs = r_pairs;
        n_first = r_first;
        n_total = r_total;
        emit    = 1'b0;
        case (r_phase)
            PH_OFFSET: begin
                if (i_item.text_char == CHAR_NEWLINE) begin
                    n_off   = '0;
                    n_pairs = '0;
                    n_first = '0;
                end else if (i_item.text_char == CHAR_SPACE
                             || r_off >= OFF_W'(OFFSET_SKIP_MAX)) begin
                    n_phase = PH_PAIR;
                    if (i_item.text_char != CHAR_SPACE) begin
                        n_first = i_item.text_char;
                        n_phase = PH_SECOND;
                    end
                end else begin
                    n_off = r_off + OFF_W'(1);
                    if (n_off >= OFF_W'(OFFSET_SKIP_MAX)) begin
                        n_phase = PH_PAIR;
                    end
                end
            end
            PH_PAIR: begin
                if (i_item.text_char == CHAR_NEWLINE) begin
                    n_phase = PH_OFFSET;
                    n_off   = '0;
                    n_pairs = '0;
                    n_first = '0;
                end else if (i_item.text_char != CHAR_SPACE) begin
                    n_first = i_item.text_char;
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (r_first != CHAR_DASH && hi_dig[4] && lo_dig[4]
                    && r_total < i_byte_limit) begin
                    emit    = 1'b1;
                    n_total = r_total + CNT_W'(1);
                end
                n_pairs = r_pairs + PAIR_W'(1);
                n_phase = (n_pairs >= PAIR_W'(PAIRS_PER_LINE)) ? PH_DISCARD : PH_PAIR;
            end
            PH_DISCARD: begin
                if (i_item.text_char == CHAR_NEWLINE) begin
                    n_phase = PH_OFFSET;
                    n_off   = '0;
                    n_pairs = '0;
                    n_first = '0;
                end
            end
            default: begin
                n_phase = PH_OFFSET;
            end
        endcase
    end

    // Result formation: a byte result, then the summary on the last character.
    always_comb begin
        byte_res                = '0;
        byte_res.byte_value     = {hi_dig[3:0], lo_dig[3:0]};
        byte_res.is_byte        = 1'b1;
        byte_res.end_of_run     = ~i_item.last_char;
        sum_res                 = '0;
        sum_res.is_summary      = 1'b1;
        sum_res.bytes_emitted   = n_total;
        sum_res.nothing_parsed  = (n_total == '0);
        sum_res.end_of_run      = 1'b1;
        o_push.first_valid      = i_fire & (emit | i_item.last_char);
        o_push.first            = emit ? byte_res : sum_res;
        o_push.second_valid     = i_fire & emit & i_item.last_char;
        o_push.second           = sum_res;
    end

    // State registers; the end of text returns everything to the line start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OFFSET;
            r_off   <= '0;
            r_pairs <= '0;
            r_first <= '0;
            r_total <= '0;
        end else if (i_fire) begin
            if (i_item.last_char) begin
                r_phase <= PH_OFFSET;
                r_off   <= '0;
                r_pairs <= '0;
                r_first <= '0;
                r_total <= '0;
            end else begin
                r_phase <= n_phase;
                r_off   <= n_off;
                r_pairs <= n_pairs;
                r_first <= n_first;
                r_total <= n_total;
            end
        end
    end

    // The last character always leaves a fresh text state behind.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.last_char) |=> (r_total == '0 && r_phase == PH_OFFSET))
        else $error("state not cleared after last character");

    // Two results from one character are a byte followed by the summary.
    a_two_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.second_valid |-> (o_push.first.is_byte && o_push.second.is_summary))
        else $error("wrong order of two results");

    // The tail of a line is only reached with a full pair count.
    a_discard_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DISCARD) |-> (r_pairs == PAIR_W'(PAIRS_PER_LINE)))
        else $error("discard phase with short pair count");

endmodule

[hdl/hdp_resq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hex dump parser result queue
// Small register queue that takes up to two results per cycle and hands
// out one result transaction per cycle on the output channel unless it stalls.
// ---------------------------------------------------------------------------
module hdp_resq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hdp_pkg::t_push i_push,
    output logic           o_space,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hdp_pkg::t_out  o_out_data
);
    import hdp_pkg::*;

    localparam int unsigned PTR_W = $clog2(RESQ_DEPTH);
    localparam int unsigned QC_W  = $clog2(RESQ_DEPTH + 1);

    t_out             r_mem [RESQ_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [QC_W-1:0]  r_count, n_count;
    logic             pop;
    logic [1:0]       push_n;

    // Output side and room for the two results of one character.
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rptr];
    assign pop         = o_out_valid & ~i_out_stall;
    assign o_space     = (r_count <= QC_W'(RESQ_DEPTH - 2));
    assign push_n      = {1'b0, i_push.first_valid} + {1'b0, i_push.second_valid};

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = r_wptr + PTR_W'(push_n);
        n_rptr  = r_rptr + PTR_W'(pop);
        n_count = r_count + QC_W'(push_n) - QC_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage; the second result goes to the slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push.first_valid) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.second_valid) begin
            r_mem[r_wptr + PTR_W'(1)] <= i_push.second;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(RESQ_DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second_valid |-> i_push.first_valid)
        else $error("second result without first");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.first_valid) |=> (r_count == $past(r_count) - QC_W'(1)))
        else $error("fill count did not drop on read");

endmodule

[hdl/hex_dump_text_parser.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hex dump text parser
// Turns hex dump text, one character per transaction, into binary bytes
// and an end-of-text summary with the byte count.
// ---------------------------------------------------------------------------
// Characters pass from the input register through the line engine to the
// result queue, one per cycle unless stalled; the queue drains one result
// per cycle unless stalled; a last character completing a byte queues two.
// The input register stalls only while the result queue lacks room for two.
// Reset (synchronous, active low) clears the line state, the byte count and
// the queue, and sets the byte limit to 1048576.
module hex_dump_text_parser #(
    parameter int unsigned PAIRS_PER_LINE  = 16,
    parameter int unsigned OFFSET_SKIP_MAX = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hdp_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  hdp_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output hdp_pkg::t_out             o_out_data
);
    import hdp_pkg::*;

    logic             r_in_valid, n_in_valid;
    t_in              r_in;
    logic [CNT_W-1:0] r_byte_limit;
    logic             space;
    logic             fire;
    logic             accept;
    t_push            push;

    // Input register handshake.
    assign fire       = r_in_valid & space;
    assign o_in_stall = r_in_valid & ~space;
    assign accept     = i_in_valid & ~o_in_stall;
    assign n_in_valid = accept | (r_in_valid & ~fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // Byte limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit <= BYTE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_byte_limit <= i_cfg_wdata;
        end
    end

    hdp_parse #(
        .PAIRS_PER_LINE  (PAIRS_PER_LINE),
        .OFFSET_SKIP_MAX (OFFSET_SKIP_MAX)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in),
        .i_byte_limit (r_byte_limit),
        .o_push       (push)
    );

    hdp_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
